>>> src/bbd_pkg.sv
// ---------------------------------------------------------------------------
// bbd_pkg: shared types and constants for the bass beat detector
// Payload structs, configuration register indexes and divider constants.
// ---------------------------------------------------------------------------
package bbd_pkg;

  localparam int BINS_SUMMED = 10;
  localparam int BIN_W       = 6;
  localparam int SAMPLE_W    = 16;
  localparam int SCALE_SH    = 4;
  localparam int SCALED_W    = SAMPLE_W - SCALE_SH;
  localparam int SUM_W       = 18;
  localparam int LEVEL_W     = 12;
  localparam int TIME_W      = 32;
  localparam int WIN_W       = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int THR_W       = 18;

  // level = trunc(sum / LEVEL_DIV), done as |sum| * DIV_MULT >> DIV_SHIFT
  localparam int    LEVEL_DIV  = 2 * BINS_SUMMED;
  localparam int    DIV_SHIFT  = SUM_W + $clog2(LEVEL_DIV);
  localparam longint DIV_MULT  = ((longint'(1) << DIV_SHIFT) + LEVEL_DIV - 1) / LEVEL_DIV;
  localparam int    MULT_W     = DIV_SHIFT + 1;
  localparam int    PROD_W     = SUM_W + MULT_W;
  localparam int    QUOT_W     = LEVEL_W + 1;

  localparam logic [BIN_W-1:0]  BIN_LAST     = BIN_W'(BINS_SUMMED - 1);
  localparam logic [WIN_W-1:0]  WINDOW_RESET = WIN_W'(100);

  typedef enum logic [0:0] {
    CFG_FLASH_ENABLE  = 1'b0,
    CFG_WINDOW_FRAMES = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_bin;
    logic signed [SAMPLE_W-1:0] right_bin;
    logic        [TIME_W-1:0]   frame_time;
  } in_req_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] bass_level;
    logic                      beat_active;
    logic                      flash_pulse;
    logic signed [LEVEL_W-1:0] peak_old;
    logic signed [LEVEL_W-1:0] floor_old;
  } out_res_t;

  typedef struct packed {
    logic             flash_enable;
    logic [WIN_W-1:0] window_frames;
  } cfg_t;

endpackage

>>> src/bbd_beat_track.sv
// ---------------------------------------------------------------------------
// bbd_beat_track: per-frame peak/floor tracking and hysteresis flag
// Holds recent and latched extremes with their time stamps; produces the
// frame result for a level and frame time when advanced.
// ---------------------------------------------------------------------------
module bbd_beat_track (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               advance,
  input  logic signed [bbd_pkg::LEVEL_W-1:0] level,
  input  logic        [bbd_pkg::TIME_W-1:0]  now,
  input  bbd_pkg::cfg_t                      cfg,
  output bbd_pkg::out_res_t                  result
);

  logic signed [bbd_pkg::LEVEL_W-1:0] max_recent_r, max_recent_nxt;
  logic signed [bbd_pkg::LEVEL_W-1:0] min_recent_r, min_recent_nxt;
  logic signed [bbd_pkg::LEVEL_W-1:0] max_latched_r, max_latched_nxt;
  logic signed [bbd_pkg::LEVEL_W-1:0] min_latched_r, min_latched_nxt;
  logic        [bbd_pkg::TIME_W-1:0]  max_stamp_r, max_stamp_nxt;
  logic        [bbd_pkg::TIME_W-1:0]  min_stamp_r, min_stamp_nxt;
  logic                               beat_flag_r, beat_flag_nxt;

  logic signed [bbd_pkg::LEVEL_W-1:0] max_upd, min_upd;
  logic        [bbd_pkg::TIME_W-1:0]  d_max, d_min, win_ext;
  logic                               pass_max, pass_min;
  logic signed [bbd_pkg::THR_W-1:0]   ext_max, ext_min, ext_lvl;
  logic signed [bbd_pkg::THR_W-1:0]   x_hi, x_lo, l10;
  logic                               above_hi, below_lo, rise, flag_mid;

  always_comb begin
    max_upd = (level > max_recent_r) ? level : max_recent_r;
    min_upd = (level < min_recent_r) ? level : min_recent_r;

    // window test on signed 32-bit time difference
    win_ext  = bbd_pkg::TIME_W'(cfg.window_frames);
    d_max    = now - max_stamp_r;
    d_min    = now - min_stamp_r;
    pass_max = !d_max[bbd_pkg::TIME_W-1] && (d_max > win_ext);
    pass_min = !d_min[bbd_pkg::TIME_W-1] && (d_min > win_ext);

    max_latched_nxt = pass_max ? max_upd : max_latched_r;
    max_recent_nxt  = pass_max ? '0 : max_upd;
    max_stamp_nxt   = pass_max ? now : max_stamp_r;
    min_latched_nxt = pass_min ? min_upd : min_latched_r;
    min_recent_nxt  = pass_min ? '0 : min_upd;
    min_stamp_nxt   = pass_min ? now : min_stamp_r;

    // thresholds compared as 10*level against 6a+4b, no division
    ext_max = bbd_pkg::THR_W'(max_latched_nxt);
    ext_min = bbd_pkg::THR_W'(min_latched_nxt);
    ext_lvl = bbd_pkg::THR_W'(level);
    x_hi    = (ext_max <<< 2) + (ext_max <<< 1) + (ext_min <<< 2);
    x_lo    = (ext_min <<< 2) + (ext_min <<< 1) + (ext_max <<< 2);
    l10     = (ext_lvl <<< 3) + (ext_lvl <<< 1);

    above_hi = x_hi[bbd_pkg::THR_W-1] ? ((l10 - 18'sd9) > x_hi) : (l10 > x_hi);
    below_lo = x_lo[bbd_pkg::THR_W-1] ? (l10 < x_lo) : ((l10 + 18'sd10) <= x_lo);

    rise          = above_hi && !beat_flag_r;
    flag_mid      = beat_flag_r || rise;
    beat_flag_nxt = flag_mid && !below_lo;

    result.bass_level  = level;
    result.beat_active = beat_flag_nxt;
    result.flash_pulse = rise && cfg.flash_enable;
    result.peak_old    = max_latched_nxt;
    result.floor_old   = min_latched_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_recent_r  <= '0;
      min_recent_r  <= '0;
      max_latched_r <= '0;
      min_latched_r <= '0;
      max_stamp_r   <= '0;
      min_stamp_r   <= '0;
      beat_flag_r   <= 1'b0;
    end else if (advance) begin
      max_recent_r  <= max_recent_nxt;
      min_recent_r  <= min_recent_nxt;
      max_latched_r <= max_latched_nxt;
      min_latched_r <= min_latched_nxt;
      max_stamp_r   <= max_stamp_nxt;
      min_stamp_r   <= min_stamp_nxt;
      beat_flag_r   <= beat_flag_nxt;
    end
  end

endmodule

>>> src/bass_beat_detector.sv
// ---------------------------------------------------------------------------
// bass_beat_detector: low-band level and hysteresis beat detection
// Input requests carry one left/right pair of low spectrum bins; every
// BINS_SUMMED-th request closes a frame and yields one result request with
// the frame level, beat flag, flash pulse and latched peak/floor. Other
// requests only accumulate and produce no result.
// Pipeline: accumulate on accept, divide stage, tracking stage into the
// output register (sum_fin_r, level2_r, out_r). Input requests are taken
// one per cycle while in_ready is high; the divide stage has one constant
// multiplier, the tracking stage a 32-bit compare per extreme.
// Reset clears the accumulator, bin count, all extremes, stamps and the
// beat flag; flash_enable resets to 0 and window_frames to 100.
// When out_ready is low the output register holds; stages behind it keep
// filling and in_ready drops only once the closing-frame stage is blocked.
// Config writes (cfg_addr 0: flash_enable, 1: window_frames) take effect at
// once; the user must make them while no frame is in flight (unenforced).
// ---------------------------------------------------------------------------
module bass_beat_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bbd_pkg::in_req_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bbd_pkg::out_res_t                out_data,
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_addr,
  input  logic [bbd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  bbd_pkg::cfg_t                       cfg_r;
  logic [bbd_pkg::BIN_W-1:0]           bin_index_r;
  logic signed [bbd_pkg::SUM_W-1:0]    level_sum_r, sum_add;
  logic signed [bbd_pkg::SUM_W-1:0]    sum_fin_r;
  logic [bbd_pkg::TIME_W-1:0]          time1_r, time2_r;
  logic                                s1_v_r, s2_v_r, out_v_r;
  logic signed [bbd_pkg::LEVEL_W-1:0]  level2_r, level_nxt;
  bbd_pkg::out_res_t                   out_r, track_res;

  logic                                in_acc, last_bin, adv2, adv3;
  logic                                sum_neg;
  logic [bbd_pkg::SUM_W-1:0]           sum_mag;
  logic [bbd_pkg::PROD_W-1:0]          prod;
  logic [bbd_pkg::QUOT_W-1:0]          quot, quot_s;

  assign adv3     = s2_v_r && (!out_v_r || out_ready);
  assign adv2     = s1_v_r && (!s2_v_r || adv3);
  assign in_ready = !s1_v_r || adv2;
  assign in_acc   = in_valid && in_ready;
  assign last_bin = (bin_index_r == bbd_pkg::BIN_LAST);

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    sum_add = level_sum_r
            + bbd_pkg::SUM_W'($signed(
                in_data.left_bin[bbd_pkg::SAMPLE_W-1:bbd_pkg::SCALE_SH]))
            + bbd_pkg::SUM_W'($signed(
                in_data.right_bin[bbd_pkg::SAMPLE_W-1:bbd_pkg::SCALE_SH]));
  end

  // truncating divide by 2*BINS_SUMMED via reciprocal multiply on magnitude
  always_comb begin
    sum_neg   = sum_fin_r[bbd_pkg::SUM_W-1];
    sum_mag   = sum_neg ? bbd_pkg::SUM_W'(-sum_fin_r) : bbd_pkg::SUM_W'(sum_fin_r);
    prod      = bbd_pkg::PROD_W'(sum_mag) *
                bbd_pkg::PROD_W'(bbd_pkg::MULT_W'(bbd_pkg::DIV_MULT));
    quot      = prod[bbd_pkg::DIV_SHIFT +: bbd_pkg::QUOT_W];
    quot_s    = sum_neg ? (~quot + 1'b1) : quot;
    level_nxt = quot_s[bbd_pkg::LEVEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flash_enable  <= 1'b0;
      cfg_r.window_frames <= bbd_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (bbd_pkg::cfg_idx_t'(cfg_addr))
        bbd_pkg::CFG_FLASH_ENABLE:  cfg_r.flash_enable  <= cfg_wdata[0];
        bbd_pkg::CFG_WINDOW_FRAMES: cfg_r.window_frames <= cfg_wdata[bbd_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_index_r <= '0;
      level_sum_r <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        if (last_bin) begin
          bin_index_r <= '0;
          level_sum_r <= '0;
        end else begin
          bin_index_r <= bin_index_r + 1'b1;
          level_sum_r <= sum_add;
        end
      end
      if (in_acc && last_bin) begin
        s1_v_r <= 1'b1;
      end else if (adv2) begin
        s1_v_r <= 1'b0;
      end
      if (adv2) begin
        s2_v_r <= 1'b1;
      end else if (adv3) begin
        s2_v_r <= 1'b0;
      end
      if (adv3) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last_bin) begin
      sum_fin_r <= sum_add;
      time1_r   <= in_data.frame_time;
    end
    if (adv2) begin
      level2_r <= level_nxt;
      time2_r  <= time1_r;
    end
    if (adv3) begin
      out_r <= track_res;
    end
  end

  bbd_beat_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (adv3),
    .level   (level2_r),
    .now     (time2_r),
    .cfg     (cfg_r),
    .result  (track_res)
  );

endmodule

>>> tb/bass_beat_detector_test.sv
// ---------------------------------------------------------------------------
// bass_beat_detector_test: self-checking bench for the bass beat detector
// Feeds bin requests, predicts each frame result with a cycle-free model
// of the level average, window latches and hysteresis flag, and compares
// result requests field by field. A short table of directed frames comes
// first, then phases of random frames under different register settings,
// with random idling on both sides, one long output stall and one phase
// without any idling.
// ---------------------------------------------------------------------------
module bass_beat_detector_test;

  typedef struct packed {
    bbd_pkg::in_req_t  req;
    logic [3:0]        reps;
    logic              checked;
    bbd_pkg::out_res_t res;
  } dir_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  bbd_pkg::in_req_t               in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  bbd_pkg::out_res_t              out_data;
  logic                           cfg_we = 1'b0;
  logic [0:0]                     cfg_addr = bbd_pkg::CFG_FLASH_ENABLE;
  logic [bbd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  bit                         flash_on = 1'b0;
  logic [bbd_pkg::WIN_W-1:0]  window_len = bbd_pkg::WINDOW_RESET;
  int                         acc_sum = 0;
  int                         bins_seen = 0;
  int                         peak_recent = 0;
  int                         peak_held = 0;
  int                         floor_recent = 0;
  int                         floor_held = 0;
  logic [bbd_pkg::TIME_W-1:0] peak_stamp = '0;
  logic [bbd_pkg::TIME_W-1:0] floor_stamp = '0;
  bit                         beat_on = 1'b0;

  bbd_pkg::out_res_t          expected_frames[$];
  bbd_pkg::out_res_t          want_res;
  int                         mismatch_count = 0;
  bit                         idle_on = 1'b1;
  bit                         hold_go = 1'b0;
  logic [bbd_pkg::TIME_W-1:0] clock_now = '0;

  bit                        phase_flash[6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
  logic [bbd_pkg::WIN_W-1:0] phase_window[6] = '{16'd3, 16'hFFFF, 16'd0, 16'd1, 16'd7,
                                                 16'd12};

  // full-scale up, full-scale down with time running backwards, then a
  // window latch on a level that truncates toward zero
  dir_row_t directed_rows[6] = '{
    '{'{16'sh7FFF, 16'sh7FFF, 32'hA5A5_5A5A}, 4'd9, 1'b0,
      '{12'sh000, 1'b0, 1'b0, 12'sh000, 12'sh000}},
    '{'{16'sh7FFF, 16'sh7FFF, 32'h0000_0000}, 4'd1, 1'b1,
      '{12'sh7FF, 1'b1, 1'b0, 12'sh000, 12'sh000}},
    '{'{16'sh8000, 16'sh8000, 32'h5A5A_A5A5}, 4'd9, 1'b0,
      '{12'sh000, 1'b0, 1'b0, 12'sh000, 12'sh000}},
    '{'{16'sh8000, 16'sh8000, 32'hFFFF_FFFF}, 4'd1, 1'b1,
      '{12'sh800, 1'b0, 1'b0, 12'sh000, 12'sh000}},
    '{'{16'sh00FF, 16'shFF00, 32'h0F0F_F0F0}, 4'd9, 1'b0,
      '{12'sh000, 1'b0, 1'b0, 12'sh000, 12'sh000}},
    '{'{16'sh00FF, 16'shFF00, 32'h0000_00C8}, 4'd1, 1'b1,
      '{12'sh000, 1'b0, 1'b0, 12'sh7FF, 12'sh800}}
  };

  bass_beat_detector dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic bit window_elapsed(input logic [bbd_pkg::TIME_W-1:0] now,
                                        input logic [bbd_pkg::TIME_W-1:0] stamp);
    logic [bbd_pkg::TIME_W-1:0] diff;
    diff = now - stamp;
    return !diff[bbd_pkg::TIME_W-1] && diff > bbd_pkg::TIME_W'(window_len);
  endfunction

  // accumulate one bin pair; on the closing bin build the frame result
  function automatic bit frame_step(input bbd_pkg::in_req_t r,
                                    output bbd_pkg::out_res_t res);
    int lvl;
    int hi_thr;
    int lo_thr;
    bit pulse;
    res = '0;
    pulse = 1'b0;
    acc_sum += (int'($signed(r.left_bin)) >>> bbd_pkg::SCALE_SH)
             + (int'($signed(r.right_bin)) >>> bbd_pkg::SCALE_SH);
    bins_seen++;
    if (bins_seen < bbd_pkg::BINS_SUMMED) return 1'b0;
    lvl = acc_sum / (2 * bbd_pkg::BINS_SUMMED);
    acc_sum = 0;
    bins_seen = 0;
    if (lvl > peak_recent) peak_recent = lvl;
    if (lvl < floor_recent) floor_recent = lvl;
    if (window_elapsed(r.frame_time, peak_stamp)) begin
      peak_held = peak_recent;
      peak_recent = 0;
      peak_stamp = r.frame_time;
    end
    if (window_elapsed(r.frame_time, floor_stamp)) begin
      floor_held = floor_recent;
      floor_recent = 0;
      floor_stamp = r.frame_time;
    end
    hi_thr = (peak_held * 6 + floor_held * 4) / 10;
    lo_thr = (peak_held * 4 + floor_held * 6) / 10;
    if (lvl > hi_thr && !beat_on) begin
      pulse = flash_on;
      beat_on = 1'b1;
    end
    if (lvl < lo_thr && beat_on) beat_on = 1'b0;
    res.bass_level  = bbd_pkg::LEVEL_W'(lvl);
    res.beat_active = beat_on;
    res.flash_pulse = pulse;
    res.peak_old    = bbd_pkg::LEVEL_W'(peak_held);
    res.floor_old   = bbd_pkg::LEVEL_W'(floor_held);
    return 1'b1;
  endfunction

  function automatic logic [bbd_pkg::SAMPLE_W-1:0] bin_near(input int base);
    int v;
    v = base + int'($urandom_range(0, 4000)) - 2000;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return bbd_pkg::SAMPLE_W'(v);
  endfunction

  task automatic offer_bin(input bbd_pkg::in_req_t r, input bit use_typed,
                           input bbd_pkg::out_res_t typed);
    bbd_pkg::out_res_t res;
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (frame_step(r, res)) expected_frames.push_back(use_typed ? typed : res);
    while (idle_on && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain(input int limit);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_frames.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(input bit fe, input logic [bbd_pkg::WIN_W-1:0] win);
    cfg_we    <= 1'b1;
    cfg_addr  <= bbd_pkg::CFG_FLASH_ENABLE;
    cfg_wdata <= bbd_pkg::CFG_DATA_W'(fe);
    @(posedge clk);
    cfg_addr  <= bbd_pkg::CFG_WINDOW_FRAMES;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_we    <= 1'b0;
    flash_on   = fe;
    window_len = win;
  endtask

  task automatic play_frame();
    bbd_pkg::in_req_t r;
    int base;
    int style;
    int step;
    style = $urandom_range(0, 9);
    base  = int'($urandom_range(0, 60000)) - 24000;
    step  = $urandom_range(0, 99);
    if (step < 75) clock_now += $urandom_range(1, 4);
    else if (step < 87) clock_now += $urandom_range(60000, 140000);
    else if (step < 97) clock_now -= $urandom_range(1, 40);
    else clock_now = $urandom();
    for (int b = 0; b < bbd_pkg::BINS_SUMMED; b++) begin
      if (style == 0) begin
        r.left_bin  = bbd_pkg::SAMPLE_W'($urandom());
        r.right_bin = bbd_pkg::SAMPLE_W'($urandom());
      end else begin
        r.left_bin  = bin_near(base);
        r.right_bin = bin_near(base);
      end
      r.frame_time = (b == bbd_pkg::BINS_SUMMED - 1) ? clock_now : $urandom();
      offer_bin(r, 1'b0, '0);
    end
  endtask

  task automatic note_field(input string name, input int want, input int got);
    $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: result request with none expected, actual %p", $time, out_data);
        mismatch_count++;
      end else begin
        want_res = expected_frames.pop_front();
        if (out_data.bass_level !== want_res.bass_level)
          note_field("bass_level", want_res.bass_level, out_data.bass_level);
        if (out_data.beat_active !== want_res.beat_active)
          note_field("beat_active", want_res.beat_active, out_data.beat_active);
        if (out_data.flash_pulse !== want_res.flash_pulse)
          note_field("flash_pulse", want_res.flash_pulse, out_data.flash_pulse);
        if (out_data.peak_old !== want_res.peak_old)
          note_field("peak_old", want_res.peak_old, out_data.peak_old);
        if (out_data.floor_old !== want_res.floor_old)
          note_field("floor_old", want_res.floor_old, out_data.floor_old);
      end
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= !idle_on || ($urandom_range(99) >= 23);
      end
    end
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++)
        offer_bin(directed_rows[i].req, directed_rows[i].checked, directed_rows[i].res);
    end
    for (int p = 0; p < 6; p++) begin
      drain(2000);
      set_config(phase_flash[p], phase_window[p]);
      clock_now = $urandom();
      idle_on = (p != 3);
      if (p == 1) hold_go = 1'b1;
      repeat (14) play_frame();
    end
    drain(10000);
    if (expected_frames.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_frames.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
src/bbd_pkg.sv
src/bbd_beat_track.sv
src/bass_beat_detector.sv
tb/bass_beat_detector_test.sv
